// ----- rtl/core/sqsc_pkg.sv -----
// shared types, constants and helpers for the sprite quad setup and cull block
package sqsc_pkg;

   localparam int unsigned MaxRecordsDefault = 4096;
   localparam int unsigned SlotLimit = 4096;

   typedef enum logic [1:0] {
      STATUS_SKIPPED = 2'd0,
      STATUS_CULLED  = 2'd1,
      STATUS_DRAWN   = 2'd2
   } status_type;

   localparam logic [2:0] CSR_SHAKE    = 3'd0;
   localparam logic [2:0] CSR_VIEW_X   = 3'd1;
   localparam logic [2:0] CSR_VIEW_Y   = 3'd2;
   localparam logic [2:0] CSR_VIEW_W   = 3'd3;
   localparam logic [2:0] CSR_VIEW_H   = 3'd4;
   localparam logic [2:0] CSR_MIX_EN   = 3'd5;
   localparam logic [2:0] CSR_MIX_ARGB = 3'd6;
   localparam logic [2:0] CSR_CAPACITY = 3'd7;

   localparam logic [7:0] KIND_ROUNDED = 8'd0;
   localparam logic [7:0] KIND_ROTATED = 8'd1;
   localparam logic [7:0] KIND_SKIP    = 8'd255;

   // one classified record handed from front to back
   typedef struct packed {
      status_type  status;
      logic [11:0] quad_index;
      logic [31:0] xl;
      logic [31:0] xr;
      logic [31:0] yt;
      logic [31:0] yb;
      logic [127:0] rot_x;
      logic [127:0] rot_y;
      logic        rotated;
      logic [31:0] vert_z;
      logic [31:0] u0;
      logic [31:0] u1;
      logic [31:0] v0;
      logic [31:0] v1;
      logic [31:0] color;
   } quad_type;

   function automatic logic [7:0] mix_channel(input logic [7:0] c, input logic [7:0] m);
      logic [15:0] p;
      begin
         p = 16'(c) * 16'(m);
         mix_channel = (p[15:7] >= 9'd256) ? 8'hFF : p[14:7];
      end
   endfunction

endpackage

// ----- rtl/core/sqsc_front.sv -----
// front end: accepts sprite records, builds the quad over several steps and culls it
module sqsc_front
   import sqsc_pkg::*;
#(
   parameter int unsigned MAX_RECORDS = MaxRecordsDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [7:0]   req_kind,
   input  logic [2:0]   req_mode_bits,
   input  logic         req_first_of_job,
   input  logic [63:0]  req_size_xy,
   input  logic [63:0]  req_scale_xy,
   input  logic [63:0]  req_pos_xy,
   input  logic signed [31:0] req_pos_z,
   input  logic [63:0]  req_sin_cos,
   input  logic [63:0]  req_uv_start,
   input  logic [63:0]  req_uv_end,
   input  logic [63:0]  req_uv_scroll,
   input  logic [63:0]  req_colors,
   input  logic [63:0]  shake_xy,
   input  logic [31:0]  view_x,
   input  logic [31:0]  view_y,
   input  logic [31:0]  view_w,
   input  logic [31:0]  view_h,
   input  logic         mix_enable,
   input  logic [31:0]  mix_argb,
   input  logic [12:0]  quad_capacity,
   output logic         q_valid,
   input  logic         q_ready,
   output quad_type     q_data
);

   localparam int unsigned CapLimit = (MAX_RECORDS < SlotLimit) ? MAX_RECORDS : SlotLimit;

   typedef enum logic [2:0] {
      S_IDLE, S_HALF, S_ROT, S_CORNER, S_CULL, S_PUSH
   } state_type;

   state_type   state_ff, state_in;
   logic [12:0] count_ff, count_in;
   logic [7:0]  kind_ff;
   logic [2:0]  mode_ff;
   logic [63:0] pos_ff, sc_ff, uvs_ff, uve_ff, uvc_ff, col_ff;
   logic signed [31:0] z_ff;
   logic signed [63:0] prodx_ff, prody_ff;
   logic signed [33:0] hx_ff, hy_ff;
   logic        ovf_ff, ovf_in;
   logic signed [33:0] cx_ff [4];
   logic signed [33:0] cy_ff [4];
   logic [1:0]  k_ff;
   logic signed [63:0] m0_ff, m1_ff, m2_ff, m3_ff;
   quad_type    out_ff, out_in;
   logic        step_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign q_valid = (state_ff == S_PUSH);
   assign q_data = out_ff;

   function automatic logic signed [63:0] sx(input logic [31:0] v);
      sx = 64'(signed'(v));
   endfunction

   function automatic logic signed [33:0] rnd(input logic signed [33:0] v);
      logic signed [33:0] q;
      logic [15:0] f;
      begin
         q = v >>> 16;
         f = v[15:0];
         if (f > 16'h8000 || (f == 16'h8000 && q[0]))
            q = q + 34'sd1;
         rnd = (q <<< 16) - 34'sd32768;
      end
   endfunction

   function automatic logic o32(input logic signed [33:0] v);
      o32 = (v < -34'sd2147483648) || (v > 34'sd2147483647);
   endfunction

   logic signed [63:0] hxw, hyw, rxw, ryw;
   logic signed [33:0] hxs, hys, ax, ay, posx, posy, shx, shy;
   logic signed [33:0] xl, xr, yt, yb, minx, maxx, miny, maxy, vx0, vy0;
   logic signed [33:0] u0, u1, v0, v1, vz;
   logic [31:0]  color;
   logic         cull;
   logic         rot_wide;
   logic [12:0]  cnt_eff;

   always_comb begin
      hxw = prodx_ff >>> 17;
      hyw = prody_ff >>> 17;
      hxs = (hxw > 64'sd2147483647) ? 34'sd2147483647 :
            (hxw < -64'sd2147483648) ? -34'sd2147483648 : 34'(hxw);
      hys = (hyw > 64'sd2147483647) ? 34'sd2147483647 :
            (hyw < -64'sd2147483648) ? -34'sd2147483648 : 34'(hyw);
      ax = k_ff[0] ? hx_ff : -hx_ff;
      ay = k_ff[1] ? hy_ff : -hy_ff;
      posx = 34'(signed'(pos_ff[31:0]));
      posy = 34'(signed'(pos_ff[63:32]));
      shx = 34'(signed'(shake_xy[31:0]));
      shy = 34'(signed'(shake_xy[63:32]));
      rxw = (m0_ff >>> 16) - (m1_ff >>> 16) + 64'(posx) + 64'(shx) +
            (mode_ff[0] ? 64'(hx_ff) : 64'sd0);
      ryw = (m2_ff >>> 16) + (m3_ff >>> 16) + 64'(posy) + 64'(shy) +
            (mode_ff[1] ? 64'(hy_ff) : 64'sd0);
      rot_wide = (rxw != 64'(34'(rxw))) || (ryw != 64'(34'(ryw)));
      xl = mode_ff[0] ? posx : posx - hx_ff;
      xr = mode_ff[0] ? posx + (hx_ff <<< 1) : posx + hx_ff;
      yt = mode_ff[1] ? posy : posy - hy_ff;
      yb = mode_ff[1] ? posy + (hy_ff <<< 1) : posy + hy_ff;
      minx = cx_ff[0]; maxx = cx_ff[0]; miny = cy_ff[0]; maxy = cy_ff[0];
      for (int i = 1; i < 4; i++) begin
         if (cx_ff[i] > maxx) maxx = cx_ff[i];
         if (cx_ff[i] < minx) minx = cx_ff[i];
         if (cy_ff[i] > maxy) maxy = cy_ff[i];
         if (cy_ff[i] < miny) miny = cy_ff[i];
      end
      vx0 = 34'(signed'(view_x));
      vy0 = 34'(signed'(view_y));
      u0 = 34'(signed'(uvs_ff[31:0])) + 34'(signed'(uvc_ff[31:0]));
      u1 = 34'(signed'(uve_ff[31:0])) + 34'(signed'(uvc_ff[31:0]));
      v0 = 34'(signed'(uvs_ff[63:32])) + 34'(signed'(uvc_ff[63:32]));
      v1 = 34'(signed'(uve_ff[63:32])) + 34'(signed'(uvc_ff[63:32]));
      vz = 34'sd65536 - (34'(z_ff) <<< 1);
      color = mode_ff[2] ? col_ff[63:32] : col_ff[31:0];
      if (mix_enable)
         for (int j = 0; j < 4; j++)
            color[j*8 +: 8] = mix_channel(color[j*8 +: 8], mix_argb[j*8 +: 8]);
      cull = ovf_ff || o32(u0) || o32(u1) || o32(v0) || o32(v1) || o32(vz);
      for (int i = 0; i < 4; i++)
         if (o32(cx_ff[i] + 34'sd32768) || o32(cy_ff[i] + 34'sd32768))
            cull = 1'b1;
      if (maxx < vx0 || maxy < vy0 || minx > vx0 + 34'(signed'(view_w)) ||
          miny > vy0 + 34'(signed'(view_h)))
         cull = 1'b1;
      cnt_eff = count_ff;
      if (32'(cnt_eff) >= ((32'(quad_capacity) < CapLimit) ? 32'(quad_capacity) : CapLimit))
         cull = 1'b1;
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ovf_in = ovf_ff;
      out_in = out_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_first_of_job) count_in = '0;
               if (req_kind == KIND_SKIP) begin
                  out_in = '0;
                  out_in.status = STATUS_SKIPPED;
                  state_in = S_PUSH;
               end else begin
                  state_in = S_HALF;
               end
            end
         end
         S_HALF: begin
            ovf_in = (hxw != 64'(hxs)) || (hyw != 64'(hys));
            state_in = (kind_ff == KIND_ROTATED) ? S_ROT : S_CORNER;
         end
         S_ROT: begin
            if (step_ff && rot_wide) ovf_in = 1'b1;
            if (step_ff && k_ff == 2'd3) state_in = S_CULL;
         end
         S_CORNER: state_in = S_CULL;
         S_CULL: begin
            out_in = '0;
            if (cull) begin
               out_in.status = STATUS_CULLED;
            end else begin
               out_in.status = STATUS_DRAWN;
               out_in.quad_index = count_ff[11:0];
               out_in.xl = 32'(cx_ff[0] + 34'sd32768);
               out_in.xr = 32'(cx_ff[1] + 34'sd32768);
               out_in.yt = 32'(cy_ff[0] + 34'sd32768);
               out_in.yb = 32'(cy_ff[2] + 34'sd32768);
               for (int i = 0; i < 4; i++) begin
                  out_in.rot_x[i*32 +: 32] = 32'(cx_ff[i] + 34'sd32768);
                  out_in.rot_y[i*32 +: 32] = 32'(cy_ff[i] + 34'sd32768);
               end
               out_in.rotated = (kind_ff == KIND_ROTATED);
               out_in.vert_z = 32'(vz);
               out_in.u0 = 32'(u0);
               out_in.u1 = 32'(u1);
               out_in.v0 = 32'(v0);
               out_in.v1 = 32'(v1);
               out_in.color = color;
               count_in = count_ff + 13'd1;
            end
            state_in = S_PUSH;
         end
         S_PUSH: if (q_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         step_ff <= 1'b0;
         k_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (state_ff == S_HALF) begin
            k_ff <= '0;
            step_ff <= 1'b0;
         end else if (state_ff == S_ROT) begin
            step_ff <= ~step_ff;
            if (step_ff) k_ff <= k_ff + 2'd1;
         end
      end
      ovf_ff <= ovf_in;
      out_ff <= out_in;
      if (state_ff == S_IDLE) begin
         kind_ff <= req_kind;
         mode_ff <= req_mode_bits;
         pos_ff <= req_pos_xy;
         z_ff <= req_pos_z;
         sc_ff <= req_sin_cos;
         uvs_ff <= req_uv_start;
         uve_ff <= req_uv_end;
         uvc_ff <= req_uv_scroll;
         col_ff <= req_colors;
         prodx_ff <= sx(req_size_xy[31:0]) * sx(req_scale_xy[31:0]);
         prody_ff <= sx(req_size_xy[63:32]) * sx(req_scale_xy[63:32]);
      end
      if (state_ff == S_HALF) begin
         hx_ff <= hxs;
         hy_ff <= hys;
      end
      if (state_ff == S_ROT) begin
         if (!step_ff) begin
            m0_ff <= 64'(ax) * sx(sc_ff[63:32]);
            m1_ff <= 64'(ay) * sx(sc_ff[31:0]);
            m2_ff <= 64'(ax) * sx(sc_ff[31:0]);
            m3_ff <= 64'(ay) * sx(sc_ff[63:32]);
         end else begin
            cx_ff[k_ff] <= 34'(rxw);
            cy_ff[k_ff] <= 34'(ryw);
         end
      end
      if (state_ff == S_CORNER) begin
         for (int i = 0; i < 4; i++) begin
            cx_ff[i] <= (kind_ff == KIND_ROUNDED) ?
                        rnd((i[0] ? xr : xl) + shx) : (i[0] ? xr : xl) + shx;
            cy_ff[i] <= (kind_ff == KIND_ROUNDED) ?
                        rnd((i[1] ? yb : yt) + shy) : (i[1] ? yb : yt) + shy;
         end
      end
   end

endmodule

// ----- rtl/core/sqsc_queue.sv -----
// two-entry queue between front and back ends
module sqsc_queue
   import sqsc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  quad_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output quad_type out_data
);

   quad_type  mem_ff [2];
   logic      wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic      push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) mem_ff[wp_ff] <= in_data;
   end

endmodule

// ----- rtl/core/sqsc_back.sv -----
// back end: emits one word per skipped or culled record or four vertex words per drawn quad
module sqsc_back
   import sqsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   output logic        q_ready,
   input  quad_type    q_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [11:0] rsp_quad_index,
   output logic [1:0]  rsp_corner,
   output logic signed [31:0] rsp_vert_x,
   output logic signed [31:0] rsp_vert_y,
   output logic signed [31:0] rsp_vert_z,
   output logic signed [31:0] rsp_tex_u,
   output logic signed [31:0] rsp_tex_v,
   output logic [31:0] rsp_vert_color,
   output logic        rsp_last
);

   logic [1:0] k_ff;
   logic       drawn;
   logic       fin;

   assign drawn = (q_data.status == STATUS_DRAWN);
   assign fin = !drawn || (k_ff == 2'd3);
   assign rsp_valid = q_valid;
   assign q_ready = rsp_ready && fin;
   assign rsp_status = q_data.status;
   assign rsp_quad_index = q_data.quad_index;
   assign rsp_corner = drawn ? k_ff : 2'd0;
   assign rsp_vert_x = !drawn ? 32'sd0 : q_data.rotated ? q_data.rot_x[k_ff*32 +: 32] :
                       (k_ff[0] ? q_data.xr : q_data.xl);
   assign rsp_vert_y = !drawn ? 32'sd0 : q_data.rotated ? q_data.rot_y[k_ff*32 +: 32] :
                       (k_ff[1] ? q_data.yb : q_data.yt);
   assign rsp_vert_z = q_data.vert_z;
   assign rsp_tex_u = !drawn ? 32'sd0 : (k_ff[0] ? q_data.u1 : q_data.u0);
   assign rsp_tex_v = !drawn ? 32'sd0 : (k_ff[1] ? q_data.v1 : q_data.v0);
   assign rsp_vert_color = q_data.color;
   assign rsp_last = fin;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0;
      end else if (q_valid && rsp_ready) begin
         k_ff <= fin ? 2'd0 : k_ff + 2'd1;
      end
   end

endmodule

// ----- rtl/core/sprite_quad_setup_cull_core.sv -----
// Sprite quad setup and cull: one record in, one word out for a skipped or culled
// record, four vertex words for a drawn quad. The front end takes a new record
// only when idle, after the last is pushed; the rotated kind builds its corners
// in a loop that shares four multipliers over eight steps, and skipped records
// go straight to push. The back end emits one word a cycle while rsp_ready is
// high; a two-entry queue lets both run apart.
module sprite_quad_setup_cull_core
   import sqsc_pkg::*;
#(
   parameter int unsigned MAX_RECORDS = MaxRecordsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_kind,
   input  logic [2:0]  req_mode_bits,
   input  logic        req_first_of_job,
   input  logic [63:0] req_size_xy,
   input  logic [63:0] req_scale_xy,
   input  logic [63:0] req_pos_xy,
   input  logic signed [31:0] req_pos_z,
   input  logic [63:0] req_sin_cos,
   input  logic [63:0] req_uv_start,
   input  logic [63:0] req_uv_end,
   input  logic [63:0] req_uv_scroll,
   input  logic [63:0] req_colors,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [11:0] rsp_quad_index,
   output logic [1:0]  rsp_corner,
   output logic signed [31:0] rsp_vert_x,
   output logic signed [31:0] rsp_vert_y,
   output logic signed [31:0] rsp_vert_z,
   output logic signed [31:0] rsp_tex_u,
   output logic signed [31:0] rsp_tex_v,
   output logic [31:0] rsp_vert_color,
   output logic        rsp_last
);

   logic [63:0] shake_ff;
   logic [31:0] vx_ff, vy_ff, vw_ff, vh_ff, argb_ff;
   logic        mix_ff;
   logic [12:0] cap_ff;
   logic        fq_valid, fq_ready, bq_valid, bq_ready;
   quad_type    fq_data, bq_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         shake_ff <= '0;
         vx_ff <= '0;
         vy_ff <= '0;
         vw_ff <= '0;
         vh_ff <= '0;
         mix_ff <= 1'b0;
         argb_ff <= '0;
         cap_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SHAKE:    shake_ff <= csr_write_data;
            CSR_VIEW_X:   vx_ff <= csr_write_data[31:0];
            CSR_VIEW_Y:   vy_ff <= csr_write_data[31:0];
            CSR_VIEW_W:   vw_ff <= csr_write_data[31:0];
            CSR_VIEW_H:   vh_ff <= csr_write_data[31:0];
            CSR_MIX_EN:   mix_ff <= csr_write_data[0];
            CSR_MIX_ARGB: argb_ff <= csr_write_data[31:0];
            CSR_CAPACITY: cap_ff <= csr_write_data[12:0];
            default: ;
         endcase
      end
   end

   sqsc_front #(.MAX_RECORDS(MAX_RECORDS)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_kind, .req_mode_bits,
      .req_first_of_job, .req_size_xy, .req_scale_xy, .req_pos_xy, .req_pos_z,
      .req_sin_cos, .req_uv_start, .req_uv_end, .req_uv_scroll, .req_colors,
      .shake_xy(shake_ff), .view_x(vx_ff), .view_y(vy_ff), .view_w(vw_ff),
      .view_h(vh_ff), .mix_enable(mix_ff), .mix_argb(argb_ff),
      .quad_capacity(cap_ff), .q_valid(fq_valid), .q_ready(fq_ready),
      .q_data(fq_data)
   );

   sqsc_queue u_queue (
      .clock, .reset, .in_valid(fq_valid), .in_ready(fq_ready), .in_data(fq_data),
      .out_valid(bq_valid), .out_ready(bq_ready), .out_data(bq_data)
   );

   sqsc_back u_back (
      .clock, .reset, .q_valid(bq_valid), .q_ready(bq_ready), .q_data(bq_data),
      .rsp_valid, .rsp_ready, .rsp_status, .rsp_quad_index, .rsp_corner,
      .rsp_vert_x, .rsp_vert_y, .rsp_vert_z, .rsp_tex_u, .rsp_tex_v,
      .rsp_vert_color, .rsp_last
   );

`ifndef SYNTHESIS
   a_last_on_corner3: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_DRAWN) |-> (rsp_last == (rsp_corner == 2'd3)))
      else $error("last flag out of step with corner");
   a_nondrawn_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_DRAWN) |-> (rsp_last && rsp_vert_x == 32'sd0))
      else $error("non-drawn word carries vertex data");
   a_corner_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=> (rsp_valid && rsp_corner != 2'd0))
      else $error("vertex sequence broken");
`endif

endmodule
